### hw/rtl/aabb_frustum_cull_defines.svh
// assertion macros for the frustum cull block
// needs clk and rst_n in the scope of each use
`ifndef AABB_FRUSTUM_CULL_DEFINES_SVH
`define AABB_FRUSTUM_CULL_DEFINES_SVH

// same-cycle implication, off while in reset
`define AFC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afc assertion failed");

// next-cycle implication, off while in reset
`define AFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afc assertion failed");

// holds in the cycle after any reset cycle
`define AFC_ASSERT_RST(label, cons) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("afc assertion failed after reset");

`endif

### hw/rtl/afc_pkg.sv
// shared constants and types for the frustum cull block
// no dependencies
`default_nettype none

package afc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int NUM_PLANES      = 6;
  localparam int COEF_W          = 16;
  localparam int PLANE_W         = 4 * COEF_W;
  localparam int CFG_IDX_W       = 3;
  localparam int D_SHIFT         = 14;
  localparam int NUM_AXES        = 3;
  // input stage plus two stages per plane cell
  localparam int PIPE_DEPTH      = 1 + 2 * NUM_PLANES;

  // coefficient slots inside a plane register
  localparam int SLOT_A = 0;
  localparam int SLOT_B = 1;
  localparam int SLOT_C = 2;
  localparam int SLOT_D = 3;

  typedef struct packed {
    logic valid;
    logic visible;
  } afc_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/afc_channels.sv
// valid/ready channel interfaces for box input and cull result
// depends on afc_pkg
`default_nettype none

interface afc_in_if #(
  parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] box_min_x;
  logic signed [COORD_WIDTH-1:0] box_min_y;
  logic signed [COORD_WIDTH-1:0] box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_x;
  logic signed [COORD_WIDTH-1:0] box_max_y;
  logic signed [COORD_WIDTH-1:0] box_max_z;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, pos_x, pos_y, pos_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, pos_x, pos_y, pos_z,
    output ready
  );
endinterface

interface afc_out_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

### hw/rtl/aabb_frustum_cull.sv
// top level of the box frustum cull block: input stage and chain of plane cells
// depends on afc_pkg, afc_channels and afc_plane_cell
`default_nettype none

// Frustum cull for axis-aligned boxes. Each input transaction carries a box
// (min and max corner) and an object position, all signed Q11.4. The block
// translates the box by the position and tests it against six planes held in
// cfg registers 0..5 (a, b, c in Q1.14 at bits 15:0, 31:16, 47:32, d in Q11.4
// at bits 63:48, all reset to zero). A box is culled (visible = 0) when all
// eight corners of it lie strictly outside one plane. The box walks a chain of
// six plane cells; each cell multiplies its coefficients by both extremes of
// every axis in one stage and adds the per-axis maxima in the next, so the
// test is exact with no rounding. One box is accepted per clock cycle while
// the output is not stalled. Stages hand data on independently, so empty
// slots are filled even while a result waits at the output. Write the plane
// registers only while no box is in flight.
module aabb_frustum_cull #(
  parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  afc_in_if.sink                                 in_ch,
  afc_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [afc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [afc_pkg::PLANE_W-1:0]       cfg_data
);

  localparam int NP       = afc_pkg::NUM_PLANES;
  localparam int NA       = afc_pkg::NUM_AXES;
  localparam int CORNER_W = COORD_WIDTH + 1;

  // chain links: index p feeds cell p, index NP is the chain output
  afc_pkg::afc_ctl_t             ctl_w   [NP+1];
  logic [NA-1:0][COORD_WIDTH:0]  lo_w    [NP+1];
  logic [NA-1:0][COORD_WIDTH:0]  hi_w    [NP+1];
  logic                          ready_w [NP+1];

  // input stage registers
  logic                          s0_valid_r;
  logic [NA-1:0][COORD_WIDTH:0]  s0_lo_r;
  logic [NA-1:0][COORD_WIDTH:0]  s0_hi_r;
  logic [NA-1:0][COORD_WIDTH:0]  lo_nxt;
  logic [NA-1:0][COORD_WIDTH:0]  hi_nxt;
  logic                          s0_ready;

  assign s0_ready    = !s0_valid_r || ready_w[0];
  assign in_ch.ready = s0_ready;

  // translated corners, one bit wider so the sum is exact
  always_comb begin
    lo_nxt[0] = CORNER_W'(in_ch.box_min_x) + CORNER_W'(in_ch.pos_x);
    lo_nxt[1] = CORNER_W'(in_ch.box_min_y) + CORNER_W'(in_ch.pos_y);
    lo_nxt[2] = CORNER_W'(in_ch.box_min_z) + CORNER_W'(in_ch.pos_z);
    hi_nxt[0] = CORNER_W'(in_ch.box_max_x) + CORNER_W'(in_ch.pos_x);
    hi_nxt[1] = CORNER_W'(in_ch.box_max_y) + CORNER_W'(in_ch.pos_y);
    hi_nxt[2] = CORNER_W'(in_ch.box_max_z) + CORNER_W'(in_ch.pos_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  // corner payload, no reset needed
  always_ff @(posedge clk) begin
    if (s0_ready) begin
      s0_lo_r <= lo_nxt;
      s0_hi_r <= hi_nxt;
    end
  end

  // every box enters the chain as visible, a cell can only clear it
  assign ctl_w[0].valid   = s0_valid_r;
  assign ctl_w[0].visible = 1'b1;
  assign lo_w[0]          = s0_lo_r;
  assign hi_w[0]          = s0_hi_r;

  // row of plane cells, each owning one plane register
  for (genvar p = 0; p < NP; p++) begin : g_cell
    afc_plane_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .CELL_INDEX  (p)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg_we    (cfg_we),
      .cfg_index (cfg_index),
      .cfg_data  (cfg_data),
      .up_ctl    (ctl_w[p]),
      .up_lo     (lo_w[p]),
      .up_hi     (hi_w[p]),
      .up_ready  (ready_w[p]),
      .dn_ctl    (ctl_w[p+1]),
      .dn_lo     (lo_w[p+1]),
      .dn_hi     (hi_w[p+1]),
      .dn_ready  (ready_w[p+1])
    );
  end

  // last cell stage doubles as the output register
  assign ready_w[NP]    = out_ch.ready;
  assign out_ch.valid   = ctl_w[NP].valid;
  assign out_ch.visible = ctl_w[NP].visible;

endmodule

`default_nettype wire

### hw/rtl/afc_plane_cell.sv
// one plane cell of the cull chain: holds one plane register and tests a box
// depends on afc_pkg
`default_nettype none

module afc_plane_cell #(
  parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF,
  parameter int CELL_INDEX  = 0
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  input  wire logic                                         cfg_we,
  input  wire logic [afc_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  wire logic [afc_pkg::PLANE_W-1:0]                  cfg_data,
  input  wire afc_pkg::afc_ctl_t                            up_ctl,
  input  wire logic [afc_pkg::NUM_AXES-1:0][COORD_WIDTH:0]  up_lo,
  input  wire logic [afc_pkg::NUM_AXES-1:0][COORD_WIDTH:0]  up_hi,
  output logic                                              up_ready,
  output afc_pkg::afc_ctl_t                                 dn_ctl,
  output logic [afc_pkg::NUM_AXES-1:0][COORD_WIDTH:0]       dn_lo,
  output logic [afc_pkg::NUM_AXES-1:0][COORD_WIDTH:0]       dn_hi,
  input  wire logic                                         dn_ready
);

  localparam int CORNER_W = COORD_WIDTH + 1;
  localparam int PROD_W   = CORNER_W + afc_pkg::COEF_W;
  localparam int SUM_W    = COORD_WIDTH + 20;
  localparam int NA       = afc_pkg::NUM_AXES;
  localparam int CW       = afc_pkg::COEF_W;

  logic [afc_pkg::PLANE_W-1:0] plane_r;

  logic                              a_valid_r;
  logic                              a_vis_r;
  logic [NA-1:0][COORD_WIDTH:0]      a_lo_r;
  logic [NA-1:0][COORD_WIDTH:0]      a_hi_r;
  logic signed [PROD_W-1:0]          a_plo_r [NA];
  logic signed [PROD_W-1:0]          a_phi_r [NA];
  logic signed [PROD_W-1:0]          plo_nxt [NA];
  logic signed [PROD_W-1:0]          phi_nxt [NA];

  logic                              b_valid_r;
  logic                              b_vis_r;
  logic [NA-1:0][COORD_WIDTH:0]      b_lo_r;
  logic [NA-1:0][COORD_WIDTH:0]      b_hi_r;

  logic                              ready_a;
  logic                              ready_b;
  logic                              all_out;
  logic signed [SUM_W-1:0]           dist_max;

  // plane register, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (cfg_we && cfg_index == afc_pkg::CFG_IDX_W'(CELL_INDEX)) begin
      plane_r <= cfg_data;
    end
  end

  assign ready_b  = !b_valid_r || dn_ready;
  assign ready_a  = !a_valid_r || ready_b;
  assign up_ready = ready_a;

  // product stage: each coefficient times both extremes of its axis
  always_comb begin
    logic signed [CW-1:0]       coef_s;
    logic signed [CORNER_W-1:0] lo_s;
    logic signed [CORNER_W-1:0] hi_s;
    for (int k = 0; k < NA; k++) begin
      coef_s     = plane_r[k*CW +: CW];
      lo_s       = up_lo[k];
      hi_s       = up_hi[k];
      plo_nxt[k] = PROD_W'(coef_s) * PROD_W'(lo_s);
      phi_nxt[k] = PROD_W'(coef_s) * PROD_W'(hi_s);
    end
  end

  // sum of per-axis maxima is the largest corner distance
  always_comb begin
    logic signed [CW-1:0] d_s;
    d_s      = plane_r[afc_pkg::SLOT_D*CW +: CW];
    dist_max = SUM_W'(d_s) <<< afc_pkg::D_SHIFT;
    for (int k = 0; k < NA; k++) begin
      if (a_plo_r[k] > a_phi_r[k]) begin
        dist_max = dist_max + SUM_W'(a_plo_r[k]);
      end else begin
        dist_max = dist_max + SUM_W'(a_phi_r[k]);
      end
    end
    all_out = dist_max[SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (ready_a) begin
        a_valid_r <= up_ctl.valid;
      end
      if (ready_b) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      a_vis_r <= up_ctl.visible;
      a_lo_r  <= up_lo;
      a_hi_r  <= up_hi;
      a_plo_r <= plo_nxt;
      a_phi_r <= phi_nxt;
    end
    if (ready_b) begin
      b_vis_r <= a_vis_r && !all_out;
      b_lo_r  <= a_lo_r;
      b_hi_r  <= a_hi_r;
    end
  end

  assign dn_ctl.valid   = b_valid_r;
  assign dn_ctl.visible = b_vis_r;
  assign dn_lo          = b_lo_r;
  assign dn_hi          = b_hi_r;

endmodule

`default_nettype wire

### hw/rtl/afc_checker.sv
// port-level checker for the frustum cull block, bound to the top level
// depends on afc_pkg and aabb_frustum_cull_defines.svh
`default_nettype none

`include "aabb_frustum_cull_defines.svh"

module afc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_visible
);

  localparam int CNT_W = $clog2(afc_pkg::PIPE_DEPTH + 1) + 1;

  logic [CNT_W-1:0] inflight_r;
  logic [CNT_W-1:0] inflight_nxt;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      inflight_nxt = inflight_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  `AFC_ASSERT_IMPL(a_no_spurious_result, out_valid, inflight_r != CNT_W'(0))
  `AFC_ASSERT_IMPL(a_depth_bound, 1'b1, inflight_r <= CNT_W'(afc_pkg::PIPE_DEPTH))
  `AFC_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(out_visible))
  `AFC_ASSERT_RST(a_empty_after_reset, !out_valid)

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_visible (out_ch.visible)
);

`default_nettype wire

### dv/afc_cull_checker.sv
`timescale 1ns / 100ps
// scoreboard for the frustum cull block: keeps its own copy of the plane
// registers, predicts visibility of every accepted box and checks the results
// depends on afc_pkg
module afc_cull_checker #(
  parameter int COORD_WIDTH = afc_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic signed [COORD_WIDTH-1:0]   in_box_min_x,
  input  logic signed [COORD_WIDTH-1:0]   in_box_min_y,
  input  logic signed [COORD_WIDTH-1:0]   in_box_min_z,
  input  logic signed [COORD_WIDTH-1:0]   in_box_max_x,
  input  logic signed [COORD_WIDTH-1:0]   in_box_max_y,
  input  logic signed [COORD_WIDTH-1:0]   in_box_max_z,
  input  logic signed [COORD_WIDTH-1:0]   in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]   in_pos_y,
  input  logic signed [COORD_WIDTH-1:0]   in_pos_z,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_visible,
  input  logic                            cfg_we,
  input  logic [afc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [afc_pkg::PLANE_W-1:0]     cfg_data,
  output int                              mismatches,
  output int                              pending
);

  logic [afc_pkg::PLANE_W-1:0] planes [afc_pkg::NUM_PLANES];
  logic                        visible_q [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report(input string what);
    $display("[%0t] cull check: %s", $time, what);
    mismatches++;
  endtask

  function automatic longint coef_of(input logic [afc_pkg::PLANE_W-1:0] plane,
                                     input int slot);
    logic signed [afc_pkg::COEF_W-1:0] c;
    c = plane[slot*afc_pkg::COEF_W +: afc_pkg::COEF_W];
    return longint'(c);
  endfunction

  // exact distance in Q.18 for all eight translated corners
  function automatic logic box_visible(input longint lo[3], input longint hi[3],
                                       input longint pos[3]);
    longint a, b, c, d, x, y, z;
    int     p, n, outside;
    for (p = 0; p < afc_pkg::NUM_PLANES; p++) begin
      a = coef_of(planes[p], afc_pkg::SLOT_A);
      b = coef_of(planes[p], afc_pkg::SLOT_B);
      c = coef_of(planes[p], afc_pkg::SLOT_C);
      d = coef_of(planes[p], afc_pkg::SLOT_D) * (longint'(1) << afc_pkg::D_SHIFT);
      outside = 0;
      for (n = 0; n < 8; n++) begin
        x = (n[2] ? hi[0] : lo[0]) + pos[0];
        y = (n[1] ? hi[1] : lo[1]) + pos[1];
        z = (n[0] ? hi[2] : lo[2]) + pos[2];
        if (a * x + b * y + c * z + d < 0) outside++;
      end
      if (outside == 8) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    longint lo[3], hi[3], pos[3];
    logic   want;
    if (!rst_n) begin
      for (int p = 0; p < afc_pkg::NUM_PLANES; p++) planes[p] <= '0;
      visible_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we && cfg_index < afc_pkg::NUM_PLANES) planes[cfg_index] <= cfg_data;
      if (out_valid && out_ready) begin
        if (visible_q.size() == 0) begin
          report($sformatf("result visible=%0b with no box waiting", out_visible));
        end else begin
          want = visible_q.pop_front();
          if (out_visible !== want)
            report($sformatf("visible=%0b, predicted %0b", out_visible, want));
        end
      end
      if (in_valid && in_ready) begin
        lo[0]  = in_box_min_x;
        lo[1]  = in_box_min_y;
        lo[2]  = in_box_min_z;
        hi[0]  = in_box_max_x;
        hi[1]  = in_box_max_y;
        hi[2]  = in_box_max_z;
        pos[0] = in_pos_x;
        pos[1] = in_pos_y;
        pos[2] = in_pos_z;
        visible_q.push_back(box_visible(lo, hi, pos));
      end
      pending <= visible_q.size();
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// top of the frustum cull testbench: clock, reset, plane register writes,
// box stimulus with random idling on both channels, watchdog and verdict
// depends on afc_pkg, afc_channels, aabb_frustum_cull and afc_cull_checker
module tb;

  localparam int CW             = afc_pkg::COORD_WIDTH_DEF;
  localparam int COEF_W         = afc_pkg::COEF_W;
  localparam int PLANE_W        = afc_pkg::PLANE_W;
  localparam int CFG_IDX_W      = afc_pkg::CFG_IDX_W;
  localparam int NUM_PLANES     = afc_pkg::NUM_PLANES;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = RANDOM_ITEMS / RANDOM_PHASES;
  // idling stops for this many boxes at the very end
  localparam int QUIET_ITEMS    = 200;
  // pipeline depth plus margin, waited out before the verdict
  localparam int SETTLE_CYCLES  = 2 * afc_pkg::PIPE_DEPTH + 4;
  // cycles with no transaction on either channel before giving up
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic signed [COEF_W-1:0] COEF_ONE  = 16'sh4000;  // 1.0 in q1.14
  localparam logic signed [COEF_W-1:0] COEF_MONE = -16'sh4000;
  localparam logic signed [COEF_W-1:0] COEF_MIN  = 16'sh8000;
  localparam logic signed [COEF_W-1:0] COEF_MAX  = 16'sh7fff;
  localparam logic signed [COEF_W-1:0] COEF_NEG1 = -16'sd1;

  // plane registers 0..5, the last two indexes decode to nothing
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_0, REG_PLANE_1, REG_PLANE_2, REG_PLANE_3,
    REG_PLANE_4, REG_PLANE_5, REG_SPARE_6, REG_SPARE_7
  } reg_idx_t;

  // families of plane sets used by the random phases
  typedef enum int { SET_CUBE, SET_TILTED, SET_RAW, SET_EXTREME } plane_set_t;

  typedef struct packed {
    logic signed [CW-1:0] min_x, min_y, min_z;
    logic signed [CW-1:0] max_x, max_y, max_z;
    logic signed [CW-1:0] pos_x, pos_y, pos_z;
  } box_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PLANE_W-1:0] cfg_data;
  logic               result_ready = 1'b0;
  bit                 idle_on = 1'b1;
  int                 stall_left = 0;
  int                 stuck_cycles = 0;
  int                 mismatch_count;
  int                 pending_count;

  afc_in_if #(.COORD_WIDTH(CW)) in_ch ();
  afc_out_if                    out_ch ();

  assign out_ch.ready = result_ready;

  aabb_frustum_cull #(.COORD_WIDTH(CW)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  afc_cull_checker #(.COORD_WIDTH(CW)) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_box_min_x (in_ch.box_min_x),
    .in_box_min_y (in_ch.box_min_y),
    .in_box_min_z (in_ch.box_min_z),
    .in_box_max_x (in_ch.box_max_x),
    .in_box_max_y (in_ch.box_max_y),
    .in_box_max_z (in_ch.box_max_z),
    .in_pos_x     (in_ch.pos_x),
    .in_pos_y     (in_ch.pos_y),
    .in_pos_z     (in_ch.pos_z),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_visible  (out_ch.visible),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatch_count),
    .pending      (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: ready drops at random while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      result_ready <= 1'b0;
      stall_left   <= 0;
    end else if (!idle_on) begin
      result_ready <= 1'b1;
    end else if (stall_left != 0) begin
      result_ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      result_ready <= 1'b0;
      stall_left   <= $urandom_range(0, 3);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // watchdog: any transaction on either channel rearms it
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // register layout: a at 15:0, b at 31:16, c at 47:32, d at 63:48
  function automatic logic [PLANE_W-1:0] pack_plane(input logic signed [COEF_W-1:0] a, b, c, d);
    return {d, c, b, a};
  endfunction

  function automatic int rand_in(input int lo, input int hi);
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  function automatic box_t make_box(input int lx, ly, lz, hx, hy, hz, px, py, pz);
    box_t b;
    b.min_x = CW'(lx);
    b.min_y = CW'(ly);
    b.min_z = CW'(lz);
    b.max_x = CW'(hx);
    b.max_y = CW'(hy);
    b.max_z = CW'(hz);
    b.pos_x = CW'(px);
    b.pos_y = CW'(py);
    b.pos_z = CW'(pz);
    return b;
  endfunction

  function automatic logic signed [COEF_W-1:0] extreme_coef();
    case ($urandom_range(0, 4))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      2:       return COEF_NEG1;
      3:       return 16'sd1;
      default: return '0;
    endcase
  endfunction

  // a quarter of the boxes are raw bits over the whole range, the rest are
  // small boxes near the origin so the planes split them both ways
  function automatic box_t rand_box();
    box_t         b;
    logic [159:0] bits;
    int           ext_x, ext_y, ext_z;
    if ($urandom_range(0, 3) == 0) begin
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
      b    = bits[$bits(box_t)-1:0];
    end else begin
      ext_x   = rand_in(0, 800);
      ext_y   = rand_in(0, 800);
      ext_z   = rand_in(0, 800);
      b.pos_x = CW'(rand_in(-3000, 3000));
      b.pos_y = CW'(rand_in(-3000, 3000));
      b.pos_z = CW'(rand_in(-3000, 3000));
      b.min_x = CW'(rand_in(-1500, 1500));
      b.min_y = CW'(rand_in(-1500, 1500));
      b.min_z = CW'(rand_in(-1500, 1500));
      b.max_x = CW'(int'(b.min_x) + ext_x);
      b.max_y = CW'(int'(b.min_y) + ext_y);
      b.max_z = CW'(int'(b.min_z) + ext_z);
      // now and then min above max on one axis, taken as given by the block
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 2))
          0:       {b.min_x, b.max_x} = {b.max_x, b.min_x};
          1:       {b.min_y, b.max_y} = {b.max_y, b.min_y};
          default: {b.min_z, b.max_z} = {b.max_z, b.min_z};
        endcase
      end
    end
    return b;
  endfunction

  // one register write per cycle, the caller drops cfg_we after the last
  task automatic write_reg(input reg_idx_t idx, input logic [PLANE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_planes(input plane_set_t set);
    logic signed [COEF_W-1:0] k [4];
    int                       half;
    half = rand_in(200, 4000);
    for (int p = 0; p < NUM_PLANES; p++) begin
      k = '{default: '0};
      case (set)
        SET_CUBE: begin
          // axis-aligned box of half width 'half': +/-axis + half >= 0
          k[afc_pkg::SLOT_A + p / 2] = (p % 2 != 0) ? COEF_MONE : COEF_ONE;
          k[afc_pkg::SLOT_D]         = COEF_W'(half);
        end
        SET_TILTED: begin
          k[afc_pkg::SLOT_A] = COEF_W'(rand_in(-16384, 16384));
          k[afc_pkg::SLOT_B] = COEF_W'(rand_in(-16384, 16384));
          k[afc_pkg::SLOT_C] = COEF_W'(rand_in(-16384, 16384));
          k[afc_pkg::SLOT_D] = COEF_W'(rand_in(-4000, 4000));
        end
        SET_EXTREME: begin
          k[afc_pkg::SLOT_A] = extreme_coef();
          k[afc_pkg::SLOT_B] = extreme_coef();
          k[afc_pkg::SLOT_C] = extreme_coef();
          k[afc_pkg::SLOT_D] = extreme_coef();
        end
        default: ;
      endcase
      if (set == SET_RAW) write_reg(reg_idx_t'(p), {$urandom, $urandom});
      else write_reg(reg_idx_t'(p), pack_plane(k[afc_pkg::SLOT_A], k[afc_pkg::SLOT_B],
                                               k[afc_pkg::SLOT_C], k[afc_pkg::SLOT_D]));
    end
    cfg_we <= 1'b0;
  endtask

  // all six planes set to one value
  task automatic load_uniform(input logic [PLANE_W-1:0] value);
    for (int p = 0; p < NUM_PLANES; p++) write_reg(reg_idx_t'(p), value);
    cfg_we <= 1'b0;
  endtask

  // offers one box, with a random gap first while idling is on, and returns
  // at the edge where the transaction is taken
  task automatic send_box(input box_t b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.box_min_x <= b.min_x;
    in_ch.box_min_y <= b.min_y;
    in_ch.box_min_z <= b.min_z;
    in_ch.box_max_x <= b.max_x;
    in_ch.box_max_y <= b.max_y;
    in_ch.box_max_z <= b.max_z;
    in_ch.pos_x     <= b.pos_x;
    in_ch.pos_y     <= b.pos_y;
    in_ch.pos_z     <= b.pos_z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop offering boxes until every predicted result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    plane_set_t set;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.box_min_x <= '0;
    in_ch.box_min_y <= '0;
    in_ch.box_min_z <= '0;
    in_ch.box_max_x <= '0;
    in_ch.box_max_y <= '0;
    in_ch.box_max_z <= '0;
    in_ch.pos_x     <= '0;
    in_ch.pos_y     <= '0;
    in_ch.pos_z     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // planes straight out of reset are all zero: every distance is zero,
    // so nothing is outside and every box stays visible
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
    drain_results();

    // only plane 0 is live (x >= 0); the spare indexes get a plane with a
    // negative offset that would cull every box if the write took effect
    write_reg(REG_PLANE_0, pack_plane(COEF_ONE, '0, '0, '0));
    for (int p = 1; p < NUM_PLANES; p++) write_reg(reg_idx_t'(p), '0);
    write_reg(REG_SPARE_6, pack_plane('0, '0, '0, COEF_NEG1));
    write_reg(REG_SPARE_7, pack_plane('0, '0, '0, COEF_NEG1));
    cfg_we <= 1'b0;
    send_box(make_box(-1, 0, 0, -1, 0, 0, 0, 0, 0));    // all corners just outside
    send_box(make_box(-1, 0, 0, 0, 0, 0, 0, 0, 0));     // straddles the plane
    send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0));      // distance exactly zero
    send_box(make_box(5, 0, 0, -3, 0, 0, 0, 0, 0));     // min above max, one side in
    send_box(make_box(-3, 0, 0, -5, 0, 0, 0, 0, 0));    // min above max, all out
    send_box(make_box(10, 0, 0, 20, 0, 0, -30, 0, 0));  // moved fully outside
    send_box(make_box(10, 0, 0, 20, 0, 0, -15, 0, 0));  // moved across the plane
    // widest translated corners: -65536 .. -1, then -1 .. 65534
    send_box(make_box(-32768, 0, 0, 32767, 0, 0, -32768, 0, 0));
    send_box(make_box(-32768, 0, 0, 32767, 0, 0, 32767, 0, 0));
    drain_results();

    // most negative coefficients everywhere
    load_uniform(pack_plane(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN));
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain_results();

    // most positive coefficients everywhere
    load_uniform(pack_plane(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX));
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain_results();

    // all register bits set: -x - y - z - 16384 in raw units, zero distance at x = -16384
    load_uniform({PLANE_W{1'b1}});
    send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_box(make_box(-8192, 0, 0, -8192, 0, 0, -8192, 0, 0));
    send_box(make_box(-8191, 0, 0, -8191, 0, 0, -8192, 0, 0));

    // random phases, each under a fresh plane set written while idle
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      case (ph % 4)
        0:       set = SET_CUBE;
        1:       set = SET_TILTED;
        2:       set = SET_RAW;
        default: set = SET_EXTREME;
      endcase
      if (ph == RANDOM_PHASES - 1) set = SET_CUBE;
      load_planes(set);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // one phase runs flat out, and the tail of the run has no idling
        idle_on <= (ph != 2) &&
                   !(ph == RANDOM_PHASES - 1 && i >= PHASE_ITEMS - QUIET_ITEMS);
        // sender holds off mid-phase until the pipeline has emptied
        if (ph == 1 && i == PHASE_ITEMS / 2) drain_results();
        send_box(rand_box());
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
